// ===== hw/rtl/urcb_pkg.sv =====
package urcb_pkg;

    // default sizes
    localparam int TEXT_DEPTH_DEF    = 64;
    localparam int HISTORY_DEPTH_DEF = 64;

    // operation codes
    localparam logic [2:0] OP_TYPE   = 3'd0;
    localparam logic [2:0] OP_DELETE = 3'd1;
    localparam logic [2:0] OP_UNDO   = 3'd2;
    localparam logic [2:0] OP_REDO   = 3'd3;
    localparam logic [2:0] OP_SHOW   = 3'd4;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_DELETE = 3'd1;
    localparam logic [2:0] ST_NO_UNDO   = 3'd2;
    localparam logic [2:0] ST_NO_REDO   = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    // history entry kind bit values
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_DELETE = 1'b1;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] char_in;
    } req_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] out_char;
        logic       char_valid;
        logic       last;
        logic [6:0] text_length;
    } res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_STREAM
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic exec_fire;
        logic show_fire;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic show_last;
    } ctl_sts_t;

endpackage

// ===== hw/rtl/urcb_ctrl.sv =====
module urcb_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic [2:0]          s_func,
    output logic                s_ready,
    output urcb_pkg::ctl_cmd_t  cmd,
    input  urcb_pkg::ctl_sts_t  sts
);
    import urcb_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (s_func) inside
                        OP_TYPE, OP_DELETE, OP_UNDO, OP_REDO: state_next = ST_EXEC;
                        OP_SHOW: state_next = ST_STREAM;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_EXEC: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_STREAM: begin
                if (sts.out_free && sts.show_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_ready       = 1'b0;
        cmd           = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            ST_EXEC: begin
                cmd.exec_fire = sts.out_free;
            end
            ST_STREAM: begin
                cmd.show_fire = sts.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/urcb_dpath.sv =====
module urcb_dpath #(
    parameter int TEXT_DEPTH    = urcb_pkg::TEXT_DEPTH_DEF,
    parameter int HISTORY_DEPTH = urcb_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  urcb_pkg::req_t      s_payload,
    input  urcb_pkg::ctl_cmd_t  cmd,
    output urcb_pkg::ctl_sts_t  sts,
    output logic                m_valid,
    input  logic                m_ready,
    output urcb_pkg::res_t      m_payload
);
    import urcb_pkg::*;

    localparam int TCW = $clog2(TEXT_DEPTH + 1);
    localparam int TAW = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
    localparam int HCW = $clog2(HISTORY_DEPTH + 1);
    localparam int HAW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int HSW = HCW + 1;

    // memories
    logic [7:0] text_mem [TEXT_DEPTH];
    logic [8:0] hist_mem [HISTORY_DEPTH];

    // control state
    logic [TCW-1:0] text_count_reg, text_count_next;
    logic [HCW-1:0] undo_count_reg, undo_count_next;
    logic [HCW-1:0] redo_count_reg, redo_count_next;
    logic [HAW-1:0] hist_base_reg, hist_base_next;
    logic           m_valid_reg;

    // payload registers
    logic [2:0]     op_reg;
    logic [7:0]     char_reg;
    logic [TCW-1:0] show_idx_reg;
    logic [7:0]     text_rdata_reg;
    logic [8:0]     hist_rdata_reg;
    res_t           res_reg;

    // memory access signals
    logic           text_we;
    logic [TAW-1:0] text_waddr;
    logic [7:0]     text_wdata;
    logic [TAW-1:0] text_raddr;
    logic           hist_we;
    logic [HAW-1:0] hist_waddr;
    logic [8:0]     hist_wdata;
    logic [HAW-1:0] hist_raddr;

    logic   text_full;
    logic   text_empty;
    logic   show_at_end;
    res_t   exec_res;
    res_t   show_res;

    // ring slot: base plus offset, wrapped once
    function automatic logic [HAW-1:0] hist_slot(input logic [HAW-1:0] base,
                                                 input logic [HCW-1:0] offset);
        logic [HSW-1:0] sum;
        sum = HSW'(base) + HSW'(offset);
        if (sum >= HSW'(HISTORY_DEPTH)) begin
            sum = sum - HSW'(HISTORY_DEPTH);
        end
        return HAW'(sum);
    endfunction

    // text address; an index outside the store maps to address zero
    function automatic logic [TAW-1:0] text_addr(input logic [TCW-1:0] idx);
        logic [TAW-1:0] a;
        a = '0;
        if (idx < TCW'(TEXT_DEPTH)) begin
            a = TAW'(idx);
        end
        return a;
    endfunction

    assign text_full   = (text_count_reg == TCW'(TEXT_DEPTH));
    assign text_empty  = (text_count_reg == '0);
    assign show_at_end = (show_idx_reg + TCW'(1) == text_count_reg);

    assign sts.out_free  = !m_valid_reg || m_ready;
    assign sts.show_last = text_empty || show_at_end;

    // read addresses
    always_comb begin
        text_raddr = '0;
        hist_raddr = '0;
        if (cmd.accept) begin
            if (s_payload.func == OP_DELETE) begin
                text_raddr = text_addr(text_count_reg - TCW'(1));
            end
            if (s_payload.func == OP_UNDO) begin
                hist_raddr = hist_slot(hist_base_reg, undo_count_reg - HCW'(1));
            end else begin
                hist_raddr = hist_slot(hist_base_reg, undo_count_reg);
            end
        end else begin
            text_raddr = text_addr(show_idx_reg + TCW'(1));
        end
    end

    // edit operation
    always_comb begin
        text_count_next = text_count_reg;
        undo_count_next = undo_count_reg;
        redo_count_next = redo_count_reg;
        hist_base_next  = hist_base_reg;
        text_we         = 1'b0;
        text_waddr      = text_addr(text_count_reg);
        text_wdata      = char_reg;
        hist_we         = 1'b0;
        hist_waddr      = hist_slot(hist_base_reg, undo_count_reg);
        hist_wdata      = {KIND_INSERT, char_reg};
        exec_res        = '0;
        exec_res.last   = 1'b1;
        exec_res.status = ST_OK;

        case (op_reg)
            OP_TYPE: begin
                if (text_full) begin
                    exec_res.status = ST_FULL;
                end else begin
                    text_we             = 1'b1;
                    text_count_next     = text_count_reg + TCW'(1);
                    hist_we             = 1'b1;
                    hist_wdata          = {KIND_INSERT, char_reg};
                    exec_res.out_char   = char_reg;
                    exec_res.char_valid = 1'b1;
                end
            end
            OP_DELETE: begin
                if (text_empty) begin
                    exec_res.status = ST_NO_DELETE;
                end else begin
                    text_count_next     = text_count_reg - TCW'(1);
                    hist_we             = 1'b1;
                    hist_wdata          = {KIND_DELETE, text_rdata_reg};
                    exec_res.out_char   = text_rdata_reg;
                    exec_res.char_valid = 1'b1;
                end
            end
            OP_UNDO: begin
                if (undo_count_reg == '0) begin
                    exec_res.status = ST_NO_UNDO;
                end else begin
                    undo_count_next = undo_count_reg - HCW'(1);
                    if (hist_rdata_reg[8] == KIND_DELETE) begin
                        if (!text_full) begin
                            text_we         = 1'b1;
                            text_wdata      = hist_rdata_reg[7:0];
                            text_count_next = text_count_reg + TCW'(1);
                        end
                    end else if (!text_empty) begin
                        text_count_next = text_count_reg - TCW'(1);
                    end
                    if (redo_count_reg != HCW'(HISTORY_DEPTH)) begin
                        redo_count_next = redo_count_reg + HCW'(1);
                    end
                    exec_res.out_char   = hist_rdata_reg[7:0];
                    exec_res.char_valid = 1'b1;
                end
            end
            OP_REDO: begin
                if (redo_count_reg == '0) begin
                    exec_res.status = ST_NO_REDO;
                end else begin
                    if (hist_rdata_reg[8] == KIND_DELETE) begin
                        if (!text_empty) begin
                            text_count_next = text_count_reg - TCW'(1);
                        end
                    end else if (!text_full) begin
                        text_we         = 1'b1;
                        text_wdata      = hist_rdata_reg[7:0];
                        text_count_next = text_count_reg + TCW'(1);
                    end
                    undo_count_next     = undo_count_reg + HCW'(1);
                    redo_count_next     = redo_count_reg - HCW'(1);
                    exec_res.out_char   = hist_rdata_reg[7:0];
                    exec_res.char_valid = 1'b1;
                end
            end
            default: begin
                exec_res.status = ST_OK;
            end
        endcase

        // recording an action: full history drops the oldest entry
        if (hist_we) begin
            redo_count_next = '0;
            if (undo_count_reg == HCW'(HISTORY_DEPTH)) begin
                if (hist_base_reg == HAW'(HISTORY_DEPTH - 1)) begin
                    hist_base_next = '0;
                end else begin
                    hist_base_next = hist_base_reg + HAW'(1);
                end
            end else begin
                undo_count_next = undo_count_reg + HCW'(1);
            end
        end

        exec_res.text_length = 7'(text_count_next);
    end

    // text streaming result
    always_comb begin
        show_res             = '0;
        show_res.status      = ST_OK;
        show_res.text_length = 7'(text_count_reg);
        if (text_empty) begin
            show_res.last = 1'b1;
        end else begin
            show_res.out_char   = text_rdata_reg;
            show_res.char_valid = 1'b1;
            show_res.last       = show_at_end;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_count_reg <= '0;
            undo_count_reg <= '0;
            redo_count_reg <= '0;
            hist_base_reg  <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cmd.exec_fire) begin
                text_count_reg <= text_count_next;
                undo_count_reg <= undo_count_next;
                redo_count_reg <= redo_count_next;
                hist_base_reg  <= hist_base_next;
            end
            if (cmd.exec_fire || cmd.show_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // transaction capture, stream index and result register
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg       <= s_payload.func;
            char_reg     <= s_payload.char_in;
            show_idx_reg <= '0;
        end else if (cmd.show_fire) begin
            show_idx_reg <= show_idx_reg + TCW'(1);
        end
        if (cmd.exec_fire) begin
            res_reg <= exec_res;
        end else if (cmd.show_fire) begin
            res_reg <= show_res;
        end
    end

    // text store
    always_ff @(posedge aclk) begin
        if (cmd.exec_fire && text_we) begin
            text_mem[text_waddr] <= text_wdata;
        end
        if (cmd.accept || cmd.show_fire) begin
            text_rdata_reg <= text_mem[text_raddr];
        end
    end

    // history store
    always_ff @(posedge aclk) begin
        if (cmd.exec_fire && hist_we) begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
        if (cmd.accept) begin
            hist_rdata_reg <= hist_mem[hist_raddr];
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = res_reg;

`ifndef SYNTHESIS
    a_text_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        text_count_reg <= TCW'(TEXT_DEPTH))
        else $error("text count beyond buffer depth");

    a_hist_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (HSW'(undo_count_reg) + HSW'(redo_count_reg)) <= HSW'(HISTORY_DEPTH))
        else $error("undo plus redo history beyond history depth");

    a_base_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        HSW'(hist_base_reg) < HSW'(HISTORY_DEPTH))
        else $error("history base outside ring");

    a_no_char_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !res_reg.char_valid) |-> (res_reg.out_char == '0))
        else $error("character not zero on a result without character");

    a_count_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        (!cmd.exec_fire) |=> $stable(text_count_reg))
        else $error("text count changed outside an edit");
`endif

endmodule

// ===== hw/rtl/undo_redo_char_buffer_core.sv =====
// Character buffer with undo and redo. Type (func 0) appends char_in, delete (1)
// removes the last character, undo (2) reverses the newest recorded edit and redo
// (3) reapplies the newest undone one; each answers one transaction with a status
// and text_length after the edit. A new type or delete clears the redo history,
// a full history drops its oldest entry, and typing into a full buffer returns
// status full. Show (4) streams the buffer, one transaction per character with
// last on the final one, or a single empty transaction when the buffer is empty;
// func 5 to 7 is taken and answers nothing. An edit first reads the stores into
// registers, then writes them and registers its result; show reads the text one
// character at a time through the single read port of the text store, reading
// each one ahead of its result. One transaction is in work at a time; the next
// is taken while a result waits, and a result that waits holds back the next one.
// No clearing pass after reset: the block is ready at once.
module undo_redo_char_buffer_core #(
    parameter int TEXT_DEPTH    = urcb_pkg::TEXT_DEPTH_DEF,
    parameter int HISTORY_DEPTH = urcb_pkg::HISTORY_DEPTH_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  urcb_pkg::req_t  s_payload,
    output logic            m_valid,
    input  logic            m_ready,
    output urcb_pkg::res_t  m_payload
);
    import urcb_pkg::*;

    ctl_cmd_t cmd;
    ctl_sts_t sts;

    // sequencer
    urcb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_func  (s_payload.func),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // stores, counters and result register
    urcb_dpath #(
        .TEXT_DEPTH    (TEXT_DEPTH),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .cmd       (cmd),
        .sts       (sts),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

// ===== tb/edit_history_checker.sv =====
module edit_history_checker #(
    parameter int TEXT_DEPTH    = urcb_pkg::TEXT_DEPTH_DEF,
    parameter int HISTORY_DEPTH = urcb_pkg::HISTORY_DEPTH_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    input  logic           s_ready,
    input  urcb_pkg::req_t s_payload,
    input  logic           m_valid,
    input  logic           m_ready,
    input  urcb_pkg::res_t m_payload,
    output int             mismatch_count,
    output int             replies_owed
);

    import urcb_pkg::*;

    // shadow copy of the buffer and the edit history
    logic [7:0] text_mem [TEXT_DEPTH];
    logic [8:0] hist_mem [HISTORY_DEPTH];
    int         text_cnt;
    int         undo_cnt;
    int         redo_cnt;
    int         hist_base;

    // replies still owed by the block, oldest first
    res_t owed_q [$];

    initial begin
        mismatch_count = 0;
        replies_owed   = 0;
    end

    function automatic void owe_reply(input logic [2:0] st, input logic [7:0] ch,
                                      input logic chv, input logic fin);
        res_t r;
        r.status      = st;
        r.out_char    = ch;
        r.char_valid  = chv;
        r.last        = fin;
        r.text_length = 7'(text_cnt);
        owed_q.push_back(r);
    endfunction

    // new edit goes on top of the undo history, redo history is dropped
    function automatic void record_action(input logic [8:0] entry);
        if (undo_cnt >= HISTORY_DEPTH) begin
            // history full: overwrite the oldest entry and slide the ring
            hist_mem[hist_base] = entry;
            hist_base = (hist_base + 1) % HISTORY_DEPTH;
        end else begin
            hist_mem[(hist_base + undo_cnt) % HISTORY_DEPTH] = entry;
            undo_cnt++;
        end
        redo_cnt = 0;
    endfunction

    // apply one accepted transaction to the shadow state and queue its replies
    function automatic void apply_edit(input req_t req);
        logic [8:0] entry;
        int         i;
        case (req.func)
            OP_TYPE: begin
                if (text_cnt >= TEXT_DEPTH) begin
                    owe_reply(ST_FULL, 8'h00, 1'b0, 1'b1);
                end else begin
                    text_mem[text_cnt] = req.char_in;
                    text_cnt++;
                    record_action({KIND_INSERT, req.char_in});
                    owe_reply(ST_OK, req.char_in, 1'b1, 1'b1);
                end
            end
            OP_DELETE: begin
                if (text_cnt == 0) begin
                    owe_reply(ST_NO_DELETE, 8'h00, 1'b0, 1'b1);
                end else begin
                    entry = {KIND_DELETE, text_mem[text_cnt - 1]};
                    text_cnt--;
                    record_action(entry);
                    owe_reply(ST_OK, entry[7:0], 1'b1, 1'b1);
                end
            end
            OP_UNDO: begin
                if (undo_cnt == 0) begin
                    owe_reply(ST_NO_UNDO, 8'h00, 1'b0, 1'b1);
                end else begin
                    undo_cnt--;
                    entry = hist_mem[(hist_base + undo_cnt) % HISTORY_DEPTH];
                    // reverse the edit: a delete puts the char back
                    if (entry[8] == KIND_DELETE) begin
                        if (text_cnt < TEXT_DEPTH) begin
                            text_mem[text_cnt] = entry[7:0];
                            text_cnt++;
                        end
                    end else if (text_cnt > 0) begin
                        text_cnt--;
                    end
                    if (redo_cnt < HISTORY_DEPTH) redo_cnt++;
                    owe_reply(ST_OK, entry[7:0], 1'b1, 1'b1);
                end
            end
            OP_REDO: begin
                if (redo_cnt == 0) begin
                    owe_reply(ST_NO_REDO, 8'h00, 1'b0, 1'b1);
                end else begin
                    entry = hist_mem[(hist_base + undo_cnt) % HISTORY_DEPTH];
                    // replay the edit as it was first done
                    if (entry[8] == KIND_DELETE) begin
                        if (text_cnt > 0) text_cnt--;
                    end else if (text_cnt < TEXT_DEPTH) begin
                        text_mem[text_cnt] = entry[7:0];
                        text_cnt++;
                    end
                    undo_cnt++;
                    redo_cnt--;
                    owe_reply(ST_OK, entry[7:0], 1'b1, 1'b1);
                end
            end
            OP_SHOW: begin
                if (text_cnt == 0) begin
                    owe_reply(ST_OK, 8'h00, 1'b0, 1'b1);
                end else begin
                    for (i = 0; i < text_cnt; i++)
                        owe_reply(ST_OK, text_mem[i], 1'b1, i == text_cnt - 1);
                end
            end
            default: begin
                // unknown operation: no state change, no reply
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("ERROR at %0t: %s", $time, what);
    endtask

    // compare one result transaction against the oldest owed reply
    task automatic check_reply(input res_t got);
        res_t want;
        if (owed_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result transaction %h", got));
            return;
        end
        want = owed_q.pop_front();
        if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.out_char !== want.out_char)
            report_mismatch($sformatf("out_char %h, expected %h", got.out_char, want.out_char));
        if (got.char_valid !== want.char_valid)
            report_mismatch($sformatf("char_valid %b, expected %b",
                                      got.char_valid, want.char_valid));
        if (got.last !== want.last)
            report_mismatch($sformatf("last %b, expected %b", got.last, want.last));
        if (got.text_length !== want.text_length)
            report_mismatch($sformatf("text_length %0d, expected %0d",
                                      got.text_length, want.text_length));
    endtask

    // monitor both channels; results are checked before new input is applied
    always @(posedge aclk) begin
        if (!aresetn) begin
            text_cnt  = 0;
            undo_cnt  = 0;
            redo_cnt  = 0;
            hist_base = 0;
            owed_q.delete();
        end else begin
            if (m_valid && m_ready) check_reply(m_payload);
            if (s_valid && s_ready) apply_edit(s_payload);
        end
        replies_owed = owed_q.size();
    end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;

    import urcb_pkg::*;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    req_t s_payload;
    logic m_valid;
    logic m_ready;
    res_t m_payload;

    int mismatch_count;
    int replies_owed;
    int replies_taken = 0;
    bit tx_burst = 1'b0;
    bit rx_burst = 1'b0;

    undo_redo_char_buffer_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    edit_history_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_payload      (s_payload),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_payload      (m_payload),
        .mismatch_count (mismatch_count),
        .replies_owed   (replies_owed)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // run limit
    initial begin
        #4000000;
        $display("Test completed with failures");
        $finish;
    end

    // result side: random stalls, one long hold-off so the block backs up
    initial begin
        int gap;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
            gap = rx_burst ? 0 : $urandom_range(0, 10);
            if (replies_taken == 60) gap = 300;
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(negedge aclk);
            while (!m_valid) @(negedge aclk);
            @(posedge aclk);
            replies_taken++;
        end
    end

    // offer one transaction after a random gap and hold it until taken
    task automatic send_op(input logic [2:0] f, input logic [7:0] c);
        int gap;
        if ($urandom_range(0, 15) == 0) tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= {f, c};
        @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        @(posedge aclk);
    endtask

    // a run of one operation with random characters
    task automatic send_run(input logic [2:0] f, input int n);
        repeat (n) send_op(f, 8'($urandom_range(0, 255)));
    endtask

    // random mix of all operations, unknown codes included
    task automatic send_mixed(input int n);
        int pick;
        logic [7:0] ch;
        repeat (n) begin
            pick = $urandom_range(0, 99);
            ch   = 8'($urandom_range(0, 255));
            if (pick < 35) send_op(OP_TYPE, ch);
            else if (pick < 55) send_op(OP_DELETE, ch);
            else if (pick < 75) send_op(OP_UNDO, ch);
            else if (pick < 90) send_op(OP_REDO, ch);
            else if (pick < 95) send_op(OP_SHOW, ch);
            else send_op(3'($urandom_range(5, 7)), ch);
        end
    endtask

    // stop offering and wait until every owed reply has come back
    task automatic drain_replies();
        s_valid <= 1'b0;
        @(posedge aclk);
        wait (replies_owed == 0);
        @(posedge aclk);
    endtask

    // stimulus and verdict
    initial begin
        s_valid   <= 1'b0;
        s_payload <= '0;
        aresetn   <= 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty cases first
        send_op(OP_SHOW, 8'h00);
        send_op(OP_DELETE, 8'hff);
        send_op(OP_UNDO, 8'h00);
        send_op(OP_REDO, 8'h00);
        // char extremes, then undo/redo of both kinds of edit
        send_op(OP_TYPE, 8'h00);
        send_op(OP_TYPE, 8'hff);
        send_op(OP_TYPE, 8'h5a);
        send_op(OP_SHOW, 8'h00);
        send_op(OP_DELETE, 8'h00);
        send_op(OP_UNDO, 8'h00);
        send_op(OP_REDO, 8'h00);
        send_op(OP_REDO, 8'h00);
        send_op(OP_UNDO, 8'h00);
        send_op(OP_UNDO, 8'h00);
        send_op(OP_REDO, 8'h00);
        // a new edit clears the redo history
        send_op(OP_TYPE, 8'ha5);
        send_op(OP_REDO, 8'h00);
        // unknown operations answer nothing
        send_op(3'd5, 8'h12);
        send_op(3'd6, 8'h34);
        send_op(3'd7, 8'hff);
        send_op(OP_SHOW, 8'h00);
        drain_replies();

        // fill the buffer past full
        send_run(OP_TYPE, 66);
        // more edits than the history holds so the oldest get dropped
        send_run(OP_DELETE, 3);
        send_run(OP_TYPE, 3);
        send_op(OP_SHOW, 8'h00);
        // unwind the whole history and past it, then replay part of it
        send_run(OP_UNDO, 70);
        send_run(OP_REDO, 40);
        send_op(OP_SHOW, 8'h00);
        send_mixed(60);

        drain_replies();
        repeat (100) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
